// ----- hdl/bshm_pkg.sv -----
// Package for the binary shrinking hit-or-miss block: item types, window geometry,
// the conditional pattern decoder and the unconditional pattern table.
// It has no dependencies. Every other file in hdl/ uses it.
`default_nettype none

package bshm_pkg;

   // Window geometry: a 5x5 window, bit row*5+col, center at row 2 col 2.
   localparam int WIN_SIDE   = 5;
   localparam int WIN_BITS   = WIN_SIDE * WIN_SIDE;
   localparam int CENTER_ROW = 2;
   localparam int CENTER_COL = 2;
   localparam int CENTER_IDX = CENTER_ROW * WIN_SIDE + CENTER_COL;
   localparam int NUM_NB     = 8;
   localparam int NUM_UNCOND = 37;

   // Neighbor offsets in the order E, NE, N, NW, W, SW, S, SE (north is the row above).
   localparam int NB_DR [NUM_NB] = '{0, -1, -1, -1, 0, 1, 1, 1};
   localparam int NB_DC [NUM_NB] = '{1, 1, 0, -1, -1, -1, 0, 1};

   // Codes of the unconditional table. Any other code means the position is ignored.
   localparam int UC_ZERO   = 0;
   localparam int UC_ONE    = 1;
   localparam int UC_PAIR   = 2;  // at least one of marks n and n+2
   localparam int UC_TRIPLE = 6;  // at least one of marks n, n+1 and n+2

   localparam int UNC_PAT [NUM_UNCOND][NUM_NB] = '{
      '{0,1,0,0,0,0,0,0}, '{0,0,0,1,0,0,0,0}, '{0,0,0,0,0,0,1,0}, '{1,0,0,0,0,0,0,0},
      '{1,1,0,0,0,0,0,0}, '{0,1,1,0,0,0,0,0}, '{0,0,1,1,0,0,0,0}, '{0,0,0,1,1,0,0,0},
      '{0,0,0,0,1,1,0,0}, '{0,0,0,0,0,1,1,0}, '{0,0,0,0,0,0,1,1}, '{1,0,0,0,0,0,0,1},
      '{0,1,1,0,1,0,0,0}, '{1,0,1,1,0,0,0,0}, '{1,0,1,0,0,0,0,1}, '{1,1,0,0,0,0,1,0},
      '{2,1,3,0,0,1,0,0}, '{0,0,2,1,3,0,0,1}, '{0,1,0,0,2,1,3,0}, '{3,0,0,1,0,0,2,1},
      '{5,5,1,1,1,5,5,5}, '{1,0,1,5,1,5,0,0}, '{1,5,1,0,1,0,0,5}, '{1,5,0,0,1,0,1,5},
      '{1,0,0,5,1,5,1,0}, '{0,5,1,5,1,0,1,0}, '{0,0,1,0,1,5,1,5}, '{1,0,1,0,0,5,1,5},
      '{1,5,1,5,0,0,1,0}, '{5,1,5,1,5,6,7,4}, '{7,4,5,1,5,1,5,6}, '{5,6,7,4,5,1,5,1},
      '{5,1,5,6,7,4,5,1}, '{1,0,1,5,0,1,0,5}, '{0,5,1,0,1,5,0,1}, '{0,1,0,5,1,0,1,5},
      '{1,5,0,1,0,5,1,0}
   };

   typedef struct packed {
      logic [WIN_BITS-1:0] window_bits;
      logic [NUM_NB-1:0]   neighbour_interior;
      logic                center_interior;
   } req_type;

   typedef struct packed {
      logic new_pixel;
      logic removed;
   } rsp_type;

   // Marks handed from the conditional stage to the unconditional stage.
   typedef struct packed {
      logic              center;
      logic              center_mark;
      logic [NUM_NB-1:0] nb_mark;
   } mark_type;

   // 8-neighbor pattern of the window pixel at (r, c), with 1 <= r, c <= 3.
   function automatic logic [NUM_NB-1:0] neigh_pattern(logic [WIN_BITS-1:0] win, int r, int c);
      logic [NUM_NB-1:0] p;
      int                n;
      int                idx;
      p = '0;
      for (n = 0; n < NUM_NB; n++) begin
         idx  = (r + NB_DR[n]) * WIN_SIDE + c + NB_DC[n];
         p[n] = win[idx[4:0]];
      end
      return p;
   endfunction

   // Conditional patterns for bonds 1 to 10. Bond 11 has none, so it never marks.
   function automatic logic cond_hit(logic [NUM_NB-1:0] p);
      logic hit;
      unique case (p) inside
         8'h02, 8'h08, 8'h20, 8'h80,
         8'h01, 8'h04, 8'h10, 8'h40,
         8'h03, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'hC0, 8'h81,
         8'h83, 8'h0E, 8'h38, 8'hE0,
         8'h0D, 8'h85, 8'h16, 8'h43, 8'h07, 8'h1C, 8'h70, 8'hC1,
         8'h8D, 8'h36,
         8'h0F, 8'h87, 8'h1E, 8'h3C, 8'h78, 8'hF0, 8'hE1, 8'hC3,
         8'h8F, 8'h3E, 8'hF8, 8'hE3,
         8'hC7, 8'h1F, 8'h7C, 8'hF1,
         8'hCF, 8'hE7, 8'h3F, 8'h9F, 8'h7E, 8'hFC, 8'hF9, 8'hF3,
         8'hEF, 8'hBF, 8'hFE, 8'hFB: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // True when the neighbor marks hit at least one unconditional pattern.
   function automatic logic uncond_hit(logic [NUM_NB-1:0] m);
      logic hit;
      logic ok;
      logic a;
      logic b;
      logic c;
      int   code;
      int   k;
      int   n;
      int   n1;
      int   n2;
      hit = 1'b0;
      for (k = 0; k < NUM_UNCOND; k++) begin
         ok = 1'b1;
         for (n = 0; n < NUM_NB; n++) begin
            code = UNC_PAT[k][n];
            n1   = (n + 1) % NUM_NB;
            n2   = (n + 2) % NUM_NB;
            a    = m[n[2:0]];
            b    = m[n1[2:0]];
            c    = m[n2[2:0]];
            if (code == UC_ZERO) begin
               ok = ok & ~a;
            end else if (code == UC_ONE) begin
               ok = ok & a;
            end else if (code == UC_PAIR) begin
               ok = ok & (a | c);
            end else if (code == UC_TRIPLE) begin
               ok = ok & (a | b | c);
            end
         end
         hit = hit | ok;
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/bshm_mark_stage.sv -----
// Conditional mark stage: marks the center and its eight neighbors from the 5x5 window.
// It depends on bshm_pkg for the item types, the window geometry and the pattern decoder.
`default_nettype none

module bshm_mark_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire bshm_pkg::req_type in_item,
   output logic                   out_valid,
   output bshm_pkg::mark_type     out_marks
);

   logic               valid_ff;
   bshm_pkg::mark_type marks_ff;
   bshm_pkg::mark_type marks_in;

   // Each pixel is marked when it is set, inside the interior and its pattern is listed.
   always_comb begin
      int r;
      int c;
      int idx;
      int k;
      marks_in = '0;
      marks_in.center = in_item.window_bits[bshm_pkg::CENTER_IDX];
      marks_in.center_mark = in_item.window_bits[bshm_pkg::CENTER_IDX]
         & in_item.center_interior
         & bshm_pkg::cond_hit(bshm_pkg::neigh_pattern(in_item.window_bits,
                                                      bshm_pkg::CENTER_ROW,
                                                      bshm_pkg::CENTER_COL));
      for (k = 0; k < bshm_pkg::NUM_NB; k++) begin
         r   = bshm_pkg::CENTER_ROW + bshm_pkg::NB_DR[k];
         c   = bshm_pkg::CENTER_COL + bshm_pkg::NB_DC[k];
         idx = r * bshm_pkg::WIN_SIDE + c;
         marks_in.nb_mark[k] = in_item.window_bits[idx[4:0]]
            & in_item.neighbour_interior[k]
            & bshm_pkg::cond_hit(bshm_pkg::neigh_pattern(in_item.window_bits, r, c));
      end
   end

   // Valid bit is cleared by reset; the marks need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      marks_ff <= marks_in;
   end

   assign out_valid = valid_ff;
   assign out_marks = marks_ff;

endmodule

`default_nettype wire

// ----- hdl/binary_shrink_hit_miss.sv -----
// Top level of the binary shrinking hit-or-miss block: one pass decision per pixel window.
// It depends on bshm_pkg and instantiates bshm_mark_stage.
//
//   port group        direction   handshake               payload
//   start / busy      in          start & !busy accepts   req_item (req_type)
//   rsp_valid         out         one-cycle strobe        rsp_item (rsp_type)
//
// An item is taken every cycle; busy is always low. Its result passes through the input
// register, conditional mark register, unconditional match register and output
// register; the pattern decodes feed the mark register and the match register.
// Synchronous reset clears the valid bits of every stage; items in flight are dropped.
// The receiver takes each result in the cycle it is shown, so nothing ever stalls.
`default_nettype none

module binary_shrink_hit_miss (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire bshm_pkg::req_type req_item,
   output logic                   busy,
   output logic                   rsp_valid,
   output bshm_pkg::rsp_type      rsp_item
);

   logic               in_valid_ff;
   bshm_pkg::req_type  in_item_ff;
   logic               mark_valid;
   bshm_pkg::mark_type marks;
   logic               uc_valid_ff;
   logic               uc_hit_ff;
   logic               uc_hit_in;
   logic               uc_center_ff;
   logic               uc_cmark_ff;
   logic               rsp_valid_ff;
   bshm_pkg::rsp_type  rsp_item_ff;
   bshm_pkg::rsp_type  rsp_item_in;

   // The pipeline never holds an item back.
   assign busy = 1'b0;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_item_ff <= req_item;
   end

   // Conditional marks of the center and its neighbors.
   bshm_mark_stage u_mark_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_item   (in_item_ff),
      .out_valid (mark_valid),
      .out_marks (marks)
   );

   // Unconditional match over the neighbor marks.
   assign uc_hit_in = bshm_pkg::uncond_hit(marks.nb_mark);

   always_ff @(posedge clock) begin
      if (reset) begin
         uc_valid_ff <= 1'b0;
      end else begin
         uc_valid_ff <= mark_valid;
      end
      uc_hit_ff    <= uc_hit_in;
      uc_center_ff <= marks.center;
      uc_cmark_ff  <= marks.center_mark;
   end

   // A marked center that hits no pattern is cleared.
   always_comb begin
      rsp_item_in.removed   = uc_cmark_ff & ~uc_hit_ff;
      rsp_item_in.new_pixel = uc_center_ff & ~rsp_item_in.removed;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= uc_valid_ff;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   // Every accepted item yields a result once it has passed the output register.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted item produced no result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 4))
      else $error("result without an accepted item");

   // Only a set center inside the interior can be removed.
   a_removed_center_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.removed) |->
         $past(req_item.window_bits[bshm_pkg::CENTER_IDX] && req_item.center_interior, 4))
      else $error("removed a pixel that could not be marked");

   a_removed_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.removed && rsp_item.new_pixel))
      else $error("removed pixel still set");
`endif

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for binary_shrink_hit_miss: drives pixel windows through the
// start/busy handshake and checks each strobed result against a local prediction.
// It depends on bshm_pkg and the block's RTL in hdl/.
`default_nettype none

module testbench;

   // Neighbor offsets in ring order E, NE, N, NW, W, SW, S, SE.
   localparam int RING_DR [8] = '{0, -1, -1, -1, 0, 1, 1, 1};
   localparam int RING_DC [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

   // Rings that let a set pixel be marked, grouped by bond 1 to 10.
   localparam int SHRINK_COUNT = 58;
   localparam bit [7:0] SHRINK_RINGS [SHRINK_COUNT] = '{
      8'h02, 8'h08, 8'h20, 8'h80,
      8'h01, 8'h04, 8'h10, 8'h40,
      8'h03, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'hC0, 8'h81,
      8'h83, 8'h0E, 8'h38, 8'hE0,
      8'h0D, 8'h85, 8'h16, 8'h43, 8'h07, 8'h1C, 8'h70, 8'hC1,
      8'h8D, 8'h36,
      8'h0F, 8'h87, 8'h1E, 8'h3C, 8'h78, 8'hF0, 8'hE1, 8'hC3,
      8'h8F, 8'h3E, 8'hF8, 8'hE3,
      8'hC7, 8'h1F, 8'h7C, 8'hF1,
      8'hCF, 8'hE7, 8'h3F, 8'h9F, 8'h7E, 8'hFC, 8'hF9, 8'hF3,
      8'hEF, 8'hBF, 8'hFE, 8'hFB
   };

   // Per-neighbor rules of the protecting patterns. CLR and SET demand that value,
   // PR2 wants mark n or n+2, TR3 wants one of n, n+1, n+2, and ANY is ignored.
   typedef enum {CLR, SET, PR2, TR3, ANY} mark_rule_type;

   localparam int RULE_COUNT = 37;
   localparam mark_rule_type MARK_RULES [RULE_COUNT][8] = '{
      '{CLR,SET,CLR,CLR,CLR,CLR,CLR,CLR}, '{CLR,CLR,CLR,SET,CLR,CLR,CLR,CLR},
      '{CLR,CLR,CLR,CLR,CLR,CLR,SET,CLR}, '{SET,CLR,CLR,CLR,CLR,CLR,CLR,CLR},
      '{SET,SET,CLR,CLR,CLR,CLR,CLR,CLR}, '{CLR,SET,SET,CLR,CLR,CLR,CLR,CLR},
      '{CLR,CLR,SET,SET,CLR,CLR,CLR,CLR}, '{CLR,CLR,CLR,SET,SET,CLR,CLR,CLR},
      '{CLR,CLR,CLR,CLR,SET,SET,CLR,CLR}, '{CLR,CLR,CLR,CLR,CLR,SET,SET,CLR},
      '{CLR,CLR,CLR,CLR,CLR,CLR,SET,SET}, '{SET,CLR,CLR,CLR,CLR,CLR,CLR,SET},
      '{CLR,SET,SET,CLR,SET,CLR,CLR,CLR}, '{SET,CLR,SET,SET,CLR,CLR,CLR,CLR},
      '{SET,CLR,SET,CLR,CLR,CLR,CLR,SET}, '{SET,SET,CLR,CLR,CLR,CLR,SET,CLR},
      '{PR2,SET,ANY,CLR,CLR,SET,CLR,CLR}, '{CLR,CLR,PR2,SET,ANY,CLR,CLR,SET},
      '{CLR,SET,CLR,CLR,PR2,SET,ANY,CLR}, '{ANY,CLR,CLR,SET,CLR,CLR,PR2,SET},
      '{ANY,ANY,SET,SET,SET,ANY,ANY,ANY}, '{SET,CLR,SET,ANY,SET,ANY,CLR,CLR},
      '{SET,ANY,SET,CLR,SET,CLR,CLR,ANY}, '{SET,ANY,CLR,CLR,SET,CLR,SET,ANY},
      '{SET,CLR,CLR,ANY,SET,ANY,SET,CLR}, '{CLR,ANY,SET,ANY,SET,CLR,SET,CLR},
      '{CLR,CLR,SET,CLR,SET,ANY,SET,ANY}, '{SET,CLR,SET,CLR,CLR,ANY,SET,ANY},
      '{SET,ANY,SET,ANY,CLR,CLR,SET,CLR}, '{ANY,SET,ANY,SET,ANY,TR3,ANY,ANY},
      '{ANY,ANY,ANY,SET,ANY,SET,ANY,TR3}, '{ANY,TR3,ANY,ANY,ANY,SET,ANY,SET},
      '{ANY,SET,ANY,TR3,ANY,ANY,ANY,SET}, '{SET,CLR,SET,ANY,CLR,SET,CLR,ANY},
      '{CLR,ANY,SET,CLR,SET,ANY,CLR,SET}, '{CLR,SET,CLR,ANY,SET,CLR,SET,ANY},
      '{SET,ANY,CLR,SET,CLR,ANY,SET,CLR}
   };

   // Sender idle chance per cycle, in percent, for each phase of the run.
   localparam int PHASE_COUNT = 3;
   localparam int IDLE_PCT [PHASE_COUNT] = '{28, 60, 0};
   localparam int ITEMS_PER_PHASE = 317;

   // The 8-neighbor ring of the window pixel at (r, c).
   function automatic bit [7:0] ring_bits(bit [bshm_pkg::WIN_BITS-1:0] w, int r, int c);
      bit [7:0] ring;
      for (int n = 0; n < 8; n++) begin
         ring[n] = w[(r + RING_DR[n]) * bshm_pkg::WIN_SIDE + c + RING_DC[n]];
      end
      return ring;
   endfunction

   // A set pixel is a removal candidate when its ring is one of the shrink rings.
   function automatic bit shrink_candidate(bit [bshm_pkg::WIN_BITS-1:0] w, int r, int c);
      bit [7:0] ring;
      if (!w[r * bshm_pkg::WIN_SIDE + c]) return 1'b0;
      ring = ring_bits(w, r, c);
      for (int k = 0; k < SHRINK_COUNT; k++) begin
         if (ring == SHRINK_RINGS[k]) return 1'b1;
      end
      return 1'b0;
   endfunction

   // True when the neighbor marks satisfy at least one protecting pattern.
   function automatic bit marks_protect(bit [7:0] marks);
      bit ok;
      bit a;
      bit b;
      bit c;
      for (int k = 0; k < RULE_COUNT; k++) begin
         ok = 1'b1;
         for (int n = 0; n < 8; n++) begin
            a = marks[n];
            b = marks[(n + 1) % 8];
            c = marks[(n + 2) % 8];
            case (MARK_RULES[k][n])
               CLR: ok = ok & ~a;
               SET: ok = ok & a;
               PR2: ok = ok & (a | c);
               TR3: ok = ok & (a | b | c);
               default: ;
            endcase
         end
         if (ok) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Expected outcome of one shrinking pass for one window.
   function automatic bshm_pkg::rsp_type predict_pass(bshm_pkg::req_type item);
      bshm_pkg::rsp_type              outcome;
      bit [bshm_pkg::WIN_BITS-1:0]    w;
      bit [7:0]                       marks;
      bit                             center;
      bit                             removed;
      w       = item.window_bits;
      center  = w[bshm_pkg::CENTER_IDX];
      removed = 1'b0;
      if (center && item.center_interior
          && shrink_candidate(w, bshm_pkg::CENTER_ROW, bshm_pkg::CENTER_COL)) begin
         for (int n = 0; n < 8; n++) begin
            marks[n] = item.neighbour_interior[n]
                       && shrink_candidate(w, bshm_pkg::CENTER_ROW + RING_DR[n],
                                           bshm_pkg::CENTER_COL + RING_DC[n]);
         end
         removed = !marks_protect(marks);
      end
      outcome.new_pixel = center & ~removed;
      outcome.removed   = removed;
      return outcome;
   endfunction

   // Holds the predicted pixel of every accepted window until its result shows up.
   class shrink_scoreboard_type;
      bshm_pkg::rsp_type pending_pixels[$];
      int unsigned       faults;

      function new();
         faults = 0;
      endfunction

      function void note_item(bshm_pkg::req_type item);
         pending_pixels = {pending_pixels, predict_pass(item)};
      endfunction

      function void check_result(bshm_pkg::rsp_type got);
         bshm_pkg::rsp_type want;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result: expected none, got new_pixel=%b removed=%b",
                     $time, got.new_pixel, got.removed);
            faults++;
            return;
         end
         want = pending_pixels.pop_front();
         if (got.new_pixel !== want.new_pixel) begin
            $display("%0t: new_pixel mismatch: expected %b, got %b",
                     $time, want.new_pixel, got.new_pixel);
            faults++;
         end
         if (got.removed !== want.removed) begin
            $display("%0t: removed mismatch: expected %b, got %b",
                     $time, want.removed, got.removed);
            faults++;
         end
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   bshm_pkg::req_type req_item  = '0;
   logic              busy;
   logic              rsp_valid;
   bshm_pkg::rsp_type rsp_item;

   shrink_scoreboard_type board = new();
   int                    idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   binary_shrink_hit_miss dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Every strobed result is taken at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_item);
   end

   // Puts a set center into the window with the given ring around it.
   function automatic bit [bshm_pkg::WIN_BITS-1:0] with_ring(bit [bshm_pkg::WIN_BITS-1:0] w,
                                                             bit [7:0] ring);
      w[bshm_pkg::CENTER_IDX] = 1'b1;
      for (int n = 0; n < 8; n++) begin
         w[(bshm_pkg::CENTER_ROW + RING_DR[n]) * bshm_pkg::WIN_SIDE
           + bshm_pkg::CENTER_COL + RING_DC[n]] = ring[n];
      end
      return w;
   endfunction

   function automatic bshm_pkg::req_type make_item(bit [bshm_pkg::WIN_BITS-1:0] w,
                                                   bit [7:0] nint, bit cint);
      bshm_pkg::req_type item;
      item.window_bits        = w;
      item.neighbour_interior = nint;
      item.center_interior    = cint;
      return item;
   endfunction

   // Mostly windows whose center is a removal candidate, with random surroundings of
   // varying density; the rest is unshaped noise.
   function automatic bshm_pkg::req_type random_item();
      bshm_pkg::req_type item;
      bit [31:0]         raw;
      bit [31:0]         mix;
      raw = $urandom;
      mix = $urandom;
      case ($urandom_range(2))
         0: raw = raw & mix;
         1: raw = raw | mix;
         default: ;
      endcase
      item.window_bits = raw[bshm_pkg::WIN_BITS-1:0];
      mix = $urandom;
      if ($urandom_range(9) < 7) begin
         item.window_bits = with_ring(item.window_bits,
                                      SHRINK_RINGS[$urandom_range(SHRINK_COUNT - 1)]);
         item.neighbour_interior = ($urandom_range(3) == 0) ? mix[7:0] : 8'hFF;
         item.center_interior    = ($urandom_range(9) != 0);
      end else begin
         item.neighbour_interior = mix[7:0];
         item.center_interior    = mix[8];
      end
      return item;
   endfunction

   // Offers one item, waits for it to be taken, then maybe idles for a while.
   task automatic send_item(input bshm_pkg::req_type item);
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_item(item);
      if ($urandom_range(99) < idle_pct) begin
         start    <= 1'b0;
         req_item <= random_item();
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   initial begin
      bit [7:0] single;
      int       drain;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         idle_pct = IDLE_PCT[phase];
         if (phase == 0) begin
            // Field extremes, a clear center and an isolated center.
            send_item(make_item('0, 8'h00, 1'b0));
            send_item(make_item('1, 8'hFF, 1'b1));
            send_item(make_item(~(25'd1 << bshm_pkg::CENTER_IDX), 8'hFF, 1'b1));
            send_item(make_item(with_ring('0, 8'h00), 8'hFF, 1'b1));
            // A lone neighbor in each direction.
            for (int n = 0; n < 8; n++) begin
               single    = '0;
               single[n] = 1'b1;
               send_item(make_item(with_ring('0, single), 8'hFF, 1'b1));
            end
            // Neighbors on the border lose their marks; a border center is kept.
            send_item(make_item(with_ring('0, 8'h01), 8'h00, 1'b1));
            send_item(make_item(with_ring('0, 8'h01), 8'hFF, 1'b0));
            // Full block, a bond-11 ring, a bond-10 ring and a bond-6 ring.
            send_item(make_item(with_ring('0, 8'hFF), 8'hFF, 1'b1));
            send_item(make_item(with_ring('0, 8'h7F), 8'hFF, 1'b1));
            send_item(make_item(with_ring('0, 8'hEF), 8'hFF, 1'b1));
            send_item(make_item(with_ring('0, 8'h0F), 8'h55, 1'b1));
            // Only the outer ring differs: it decides the neighbor marks.
            send_item(make_item(with_ring(25'h1F8C63F, 8'h03), 8'hFF, 1'b1));
            send_item(make_item(with_ring('0, 8'h03), 8'hFF, 1'b1));
         end
         repeat (ITEMS_PER_PHASE) send_item(random_item());
      end
      start <= 1'b0;

      // Let the pipeline drain, then keep watching for stray results.
      drain = 0;
      while (board.pending_pixels.size() != 0 && drain < 100) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (board.pending_pixels.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, board.pending_pixels.size());
         board.faults += board.pending_pixels.size();
      end

      if (board.faults == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop in case the handshake hangs.
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ----- binary_shrink_hit_miss.f -----
hdl/bshm_pkg.sv
hdl/bshm_mark_stage.sv
hdl/binary_shrink_hit_miss.sv
bench/testbench.sv
